// ===== rtl/rsip_pkg.sv =====
package rsip_pkg;

   // Value and accumulator widths
   localparam int VALUE_WIDTH  = 32;
   localparam int MAG_WIDTH    = VALUE_WIDTH - 1;
   localparam int RADIX_WIDTH  = 6;
   localparam int CHAR_WIDTH   = 8;
   localparam int DIGIT_WIDTH  = 6;
   localparam int STATUS_WIDTH = 2;

   // Register port
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_IDX_WIDTH  = CSR_ADDR_WIDTH - 2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_IDX_RADIX = '0;

   localparam logic [RADIX_WIDTH-1:0] RADIX_RESET = RADIX_WIDTH'(10);
   localparam logic [RADIX_WIDTH-1:0] RADIX_MIN   = RADIX_WIDTH'(2);
   localparam logic [RADIX_WIDTH-1:0] RADIX_MAX   = RADIX_WIDTH'(36);

   localparam logic [DIGIT_WIDTH-1:0] DIGIT_NONE  = DIGIT_WIDTH'(36);
   localparam logic [DIGIT_WIDTH-1:0] DIGIT_ALPHA = DIGIT_WIDTH'(10);

   localparam logic [MAG_WIDTH-1:0] MAG_MAX = '1;

   // Result status codes
   localparam logic [STATUS_WIDTH-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_BASE    = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_OVER    = 2'd2;
   localparam logic [STATUS_WIDTH-1:0] ST_INVALID = 2'd3;

   // Character codes
   localparam logic [CHAR_WIDTH-1:0] CH_TAB    = 8'h09;
   localparam logic [CHAR_WIDTH-1:0] CH_CR     = 8'h0D;
   localparam logic [CHAR_WIDTH-1:0] CH_SPACE  = 8'h20;
   localparam logic [CHAR_WIDTH-1:0] CH_PLUS   = 8'h2B;
   localparam logic [CHAR_WIDTH-1:0] CH_MINUS  = 8'h2D;
   localparam logic [CHAR_WIDTH-1:0] CH_DIG_0  = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CH_DIG_9  = 8'h39;
   localparam logic [CHAR_WIDTH-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CHAR_WIDTH-1:0] CH_UPPER_Z = 8'h5A;
   localparam logic [CHAR_WIDTH-1:0] CH_LOWER_A = 8'h61;
   localparam logic [CHAR_WIDTH-1:0] CH_LOWER_Z = 8'h7A;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] char_code;
      logic                  last_char;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] value;
      logic [STATUS_WIDTH-1:0]       status;
   } rsp_type;

   // Digit value of a character; DIGIT_NONE for anything not 0-9, a-z, A-Z
   function automatic logic [DIGIT_WIDTH-1:0] digit_of(input logic [CHAR_WIDTH-1:0] c);
      logic [CHAR_WIDTH-1:0] d;
      begin
         d = {CHAR_WIDTH{1'b0}};
         if (c >= CH_DIG_0 && c <= CH_DIG_9) begin
            d = c - CH_DIG_0;
         end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            d = c - CH_LOWER_A + CHAR_WIDTH'(DIGIT_ALPHA);
         end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            d = c - CH_UPPER_A + CHAR_WIDTH'(DIGIT_ALPHA);
         end else begin
            d = CHAR_WIDTH'(DIGIT_NONE);
         end
         return d[DIGIT_WIDTH-1:0];
      end
   endfunction

endpackage

// ===== rtl/rsip_csr.sv =====
module rsip_csr
   import rsip_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready,
   output logic [RADIX_WIDTH-1:0]    radix
);

   logic [RADIX_WIDTH-1:0]   radix_ff;
   logic [CSR_IDX_WIDTH-1:0] reg_idx;
   logic                     wr_en;

   assign reg_idx = paddr[CSR_ADDR_WIDTH-1:2];
   assign wr_en   = psel && penable && pwrite && pready;
   assign pready  = 1'b1;
   assign radix   = radix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else if (wr_en && reg_idx == CSR_IDX_RADIX) begin
         radix_ff <= pwdata[RADIX_WIDTH-1:0];
      end
   end

   always_comb begin
      unique case (reg_idx)
         CSR_IDX_RADIX: prdata = CSR_DATA_WIDTH'(radix_ff);
         default:       prdata = '0;
      endcase
   end

endmodule

// ===== rtl/rsip_core.sv =====
module rsip_core
   import rsip_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [RADIX_WIDTH-1:0] radix,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   res_valid,
   output rsp_type                res_data,
   input  logic                   res_free
);

   localparam int PROD_WIDTH = MAG_WIDTH + RADIX_WIDTH;
   localparam int ACC_WIDTH  = PROD_WIDTH + 1;

   localparam logic PH_SPACE  = 1'b0;
   localparam logic PH_DIGITS = 1'b1;

   // Input register
   logic    s1_valid_ff;
   req_type s1_data_ff;
   logic    s1_fire;
   logic    s1_last;

   // String state
   logic                    phase_ff, phase_in;
   logic                    neg_ff, neg_in;
   logic [MAG_WIDTH-1:0]    mag_ff, mag_in;
   logic [STATUS_WIDTH-1:0] err_ff, err_in;

   logic [CHAR_WIDTH-1:0]  ch;
   logic [DIGIT_WIDTH-1:0] digit;
   logic                   base_bad;
   logic                   is_space;
   logic                   is_sign;
   logic [PROD_WIDTH-1:0]  prod;
   logic [ACC_WIDTH-1:0]   acc;
   logic                   over;
   logic [VALUE_WIDTH-1:0] mag_ext;

   assign s1_last   = s1_data_ff.last_char;
   assign s1_fire   = s1_valid_ff && (!s1_last || res_free);
   assign req_ready = !s1_valid_ff || s1_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_data_ff <= req_data;
      end
   end

   assign ch       = s1_data_ff.char_code;
   assign digit    = digit_of(ch);
   assign base_bad = (radix < RADIX_MIN) || (radix > RADIX_MAX);
   assign is_space = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
   assign is_sign  = (ch == CH_MINUS) || (ch == CH_PLUS);

   // One multiply-add; overflow when the new magnitude would pass MAG_MAX
   assign prod = PROD_WIDTH'(mag_ff) * PROD_WIDTH'(radix);
   assign acc  = {1'b0, prod} + ACC_WIDTH'(digit);
   assign over = acc > ACC_WIDTH'(MAG_MAX);

   always_comb begin
      phase_in = phase_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      err_in   = err_ff;
      if (err_ff == ST_OK) begin
         if (base_bad) begin
            err_in = ST_BASE;
         end else if (phase_ff == PH_SPACE && is_space) begin
            phase_in = PH_SPACE;
         end else if (phase_ff == PH_SPACE && is_sign) begin
            neg_in   = (ch == CH_MINUS);
            phase_in = PH_DIGITS;
         end else begin
            phase_in = PH_DIGITS;
            if (digit >= radix) begin
               err_in = ST_INVALID;
            end else if (over) begin
               err_in = ST_OVER;
            end else begin
               mag_in = acc[MAG_WIDTH-1:0];
            end
         end
      end
   end

   assign mag_ext = {1'b0, mag_in};

   always_comb begin
      res_data.status = err_in;
      if (err_in != ST_OK) begin
         res_data.value = '0;
      end else if (neg_in) begin
         res_data.value = $signed(VALUE_WIDTH'(0) - mag_ext);
      end else begin
         res_data.value = $signed(mag_ext);
      end
   end

   assign res_valid = s1_fire && s1_last;

   // Advance on every character; clear at the end of a string
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SPACE;
         neg_ff   <= 1'b0;
         mag_ff   <= '0;
         err_ff   <= ST_OK;
      end else if (s1_fire) begin
         if (s1_last) begin
            phase_ff <= PH_SPACE;
            neg_ff   <= 1'b0;
            mag_ff   <= '0;
            err_ff   <= ST_OK;
         end else begin
            phase_ff <= phase_in;
            neg_ff   <= neg_in;
            mag_ff   <= mag_in;
            err_ff   <= err_in;
         end
      end
   end

`ifndef SYNTHESIS
   a_clear_after_string: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_last) |=>
         (err_ff == ST_OK && mag_ff == '0 && phase_ff == PH_SPACE && !neg_ff))
      else $error("string state not cleared after result");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      (err_ff != ST_OK && !(s1_fire && s1_last)) |=> (err_ff == $past(err_ff)))
      else $error("error code changed within a string");

   a_no_mag_before_digits: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SPACE) |-> (mag_ff == '0 && !neg_ff))
      else $error("magnitude or sign set before digit phase");

   a_no_min_value: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> (res_data.value != $signed({1'b1, {MAG_WIDTH{1'b0}}})))
      else $error("most negative value produced");
`endif

endmodule

// ===== rtl/rsip_out_reg.sv =====
module rsip_out_reg
   import rsip_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  rsp_type in_data,
   output logic    out_free,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    valid_ff;
   rsp_type data_ff;

   assign out_free  = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (out_free) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && out_free) begin
         data_ff <= in_data;
      end
   end

endmodule

// ===== rtl/radix_string_to_int_parser.sv =====
// Radix string-to-integer parser. Feed a number string one ASCII character per
// request, with last_char set on its final character; the block skips leading
// whitespace, takes one optional '+' or '-', then accumulates digits 0-9 and
// letters a-z/A-Z (case ignored) in the base held in the radix register
// (byte address 0, 6 bits, reset 10, valid 2 to 36). Only the request marked
// last_char produces a response: the signed 32-bit value and a status of ok,
// bad base, overflow (magnitude above 2^31-1) or invalid character. Any
// character that is not a digit of the base after the prefix is invalid, the
// first error of a string sticks and forces the value to 0, and all string
// state clears after each response. A string of only whitespace and/or a sign
// reports 0 with status ok. Throughput is one character per clock, unless a
// last character waits for a full response register: each character passes
// an input register and one 31x6-bit multiply-add with its overflow compare
// into the string state; a last character's result lands in the response
// register. The response register decouples the two sides: further characters
// up to the next last character are still taken while a finished response
// waits for rsp_ready. Write the radix only while no string is in flight.
module radix_string_to_int_parser
   import rsip_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // Character requests
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,
   // Parse responses
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_data,
   // Register port
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   logic [RADIX_WIDTH-1:0] radix;
   logic                   res_valid;
   rsp_type                res_data;
   logic                   res_free;

   // Radix register
   rsip_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .radix   (radix)
   );

   // Input register, string state and the per-character multiply-add
   rsip_core u_core (
      .clock     (clock),
      .reset     (reset),
      .radix     (radix),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .res_valid (res_valid),
      .res_data  (res_data),
      .res_free  (res_free)
   );

   // Response register; hold the result until the consumer takes it
   rsip_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res_data),
      .out_free  (res_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== bench/radix_string_to_int_parser_monitor.sv =====
`timescale 1ns / 1ps

module radix_string_to_int_parser_monitor
   import rsip_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  req_type                   req_data,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  rsp_type                   rsp_data,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   input  logic [CSR_DATA_WIDTH-1:0] prdata,
   input  logic                      pready,
   output int                        mismatches,
   output int                        results_owed
);

   typedef enum logic [1:0] {SCAN_SPACE, SCAN_DIGITS} scan_phase_type;

   logic [RADIX_WIDTH-1:0]  base_reg;
   scan_phase_type          scan;
   logic                    minus;
   logic [MAG_WIDTH-1:0]    accum;
   logic [STATUS_WIDTH-1:0] fault;
   rsp_type                 parsed_results[$];

   task automatic note_failure(input string text);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t: MISMATCH %s", $realtime, text);
      end
   endtask

   function automatic int char_digit(input logic [CHAR_WIDTH-1:0] c);
      if (c >= CH_DIG_0 && c <= CH_DIG_9) begin
         return int'(c - CH_DIG_0);
      end
      if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
         return int'(c - CH_LOWER_A) + int'(DIGIT_ALPHA);
      end
      if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
         return int'(c - CH_UPPER_A) + int'(DIGIT_ALPHA);
      end
      return int'(DIGIT_NONE);
   endfunction

   function automatic void restart_string();
      scan  = SCAN_SPACE;
      minus = 1'b0;
      accum = '0;
      fault = ST_OK;
   endfunction

   // Advance the parse by one character; the first error sticks.
   function automatic void fold_char(input logic [CHAR_WIDTH-1:0] c);
      int          digit;
      logic [63:0] grown;
      if (fault != ST_OK) begin
         return;
      end
      if (base_reg < RADIX_MIN || base_reg > RADIX_MAX) begin
         fault = ST_BASE;
         return;
      end
      if (scan == SCAN_SPACE) begin
         if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
            return;
         end
         scan = SCAN_DIGITS;
         if (c == CH_PLUS || c == CH_MINUS) begin
            minus = (c == CH_MINUS);
            return;
         end
      end
      digit = char_digit(c);
      if (digit >= int'(base_reg)) begin
         fault = ST_INVALID;
         return;
      end
      grown = 64'(accum) * 64'(base_reg) + 64'(digit);
      if (grown > 64'(MAG_MAX)) begin
         fault = ST_OVER;
         return;
      end
      accum = grown[MAG_WIDTH-1:0];
   endfunction

   always @(posedge clock) begin : observe
      rsp_type want;
      if (reset) begin
         base_reg = RADIX_RESET;
         restart_string();
         parsed_results.delete();
      end else begin
         // responses leave before this edge's request joins the queue
         if (rsp_valid && rsp_ready) begin
            if (parsed_results.size() == 0) begin
               note_failure($sformatf("unexpected response value %0d status %0d",
                                      rsp_data.value, rsp_data.status));
            end else begin
               want = parsed_results.pop_front();
               if (rsp_data.value !== want.value || rsp_data.status !== want.status) begin
                  note_failure($sformatf("value exp %0d got %0d, status exp %0d got %0d",
                                         want.value, rsp_data.value,
                                         want.status, rsp_data.status));
               end
            end
         end
         if (req_valid && req_ready) begin
            fold_char(req_data.char_code);
            if (req_data.last_char) begin
               want.status = fault;
               if (fault != ST_OK) begin
                  want.value = '0;
               end else if (minus) begin
                  want.value = VALUE_WIDTH'(0) - VALUE_WIDTH'(accum);
               end else begin
                  want.value = VALUE_WIDTH'(accum);
               end
               parsed_results.push_back(want);
               restart_string();
            end
         end
         if (psel && penable && pready && paddr[CSR_ADDR_WIDTH-1:2] == CSR_IDX_RADIX) begin
            if (pwrite) begin
               base_reg = pwdata[RADIX_WIDTH-1:0];
            end else if (prdata !== CSR_DATA_WIDTH'(base_reg)) begin
               note_failure($sformatf("radix read exp %0d got %0d", base_reg, prdata));
            end
         end
      end
      results_owed = parsed_results.size();
   end

endmodule

// ===== bench/radix_string_to_int_parser_test.sv =====
`timescale 1ns / 1ps

module radix_string_to_int_parser_test
   import rsip_pkg::*;
;

   localparam int RANDOM_CHARS = 1450;
   localparam int HOLD_CYCLES  = 200;

   logic                      clock;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   req_type                   req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rsp_type                   rsp_data;
   logic                      psel      = 1'b0;
   logic                      penable   = 1'b0;
   logic                      pwrite    = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] paddr     = '0;
   logic [CSR_DATA_WIDTH-1:0] pwdata    = '0;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   int mismatches;
   int results_owed;

   // Stimulus knobs shared with the receiver process
   int   sent_chars    = 0;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   int   hold_at       = 32'h7fff_ffff;
   bit   hold_done     = 1'b0;

   logic [RADIX_WIDTH-1:0] radix_now = RADIX_RESET;
   logic [RADIX_WIDTH-1:0] radix_plan [0:8] =
      '{6'd2, 6'd36, 6'd0, 6'd16, 6'd63, 6'd10, 6'd1, 6'd37, 6'd8};
   logic [CHAR_WIDTH-1:0]  text[$];

   radix_string_to_int_parser DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   radix_string_to_int_parser_monitor watch (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .mismatches   (mismatches),
      .results_owed (results_owed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case a handshake never completes
   initial begin
      #2_000_000;
      $display("radix_string_to_int_parser_test: done, errors");
      $finish;
   end

   // Receiver: stall at random; once, well into the run, hold off for a long
   // stretch so the response register fills and the block backs up its input.
   initial begin
      forever begin
         @(negedge clock);
         if (!hold_done && sent_chars >= hold_at) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Offer one character request; return at the falling edge after it is
   // taken, with valid still high so a back-to-back request needs no toggle.
   task automatic push_char(input logic [CHAR_WIDTH-1:0] c, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{char_code: c, last_char: last};
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      sent_chars++;
   endtask

   task automatic push_string(input string s);
      for (int i = 0; i < s.len(); i++) begin
         push_char(s[i], i == s.len() - 1);
      end
   endtask

   task automatic push_text();
      foreach (text[i]) begin
         push_char(text[i], i == text.size() - 1);
      end
   endtask

   // Drop valid, drain every outstanding response, then let the pipeline empty.
   task automatic settle();
      req_valid <= 1'b0;
      while (results_owed != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // One register access: a setup phase, an access phase, then a quiet phase.
   task automatic csr_cycle(input logic is_write, input logic [CSR_DATA_WIDTH-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= {CSR_IDX_RADIX, 2'b00};
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_radix(input logic [RADIX_WIDTH-1:0] r);
      radix_now = r;
      // upper data bits are junk; only the low six bits are stored
      csr_cycle(1'b1, {(CSR_DATA_WIDTH - RADIX_WIDTH)'($urandom), r});
      csr_cycle(1'b0, '0);
   endtask

   function automatic logic [CHAR_WIDTH-1:0] digit_char(input int d);
      if (d < 10) begin
         return CH_DIG_0 + CHAR_WIDTH'(d);
      end
      return ($urandom_range(1) ? CH_UPPER_A : CH_LOWER_A) + CHAR_WIDTH'(d - 10);
   endfunction

   function automatic logic [CHAR_WIDTH-1:0] space_char();
      int pick;
      pick = $urandom_range(8, 13);
      return (pick == 8) ? CH_SPACE : CHAR_WIDTH'(pick);
   endfunction

   // Build one string into text: mostly well-formed numbers in the current
   // base, some with one character broken, and some pure byte noise.
   task automatic build_string();
      int                    kind;
      int                    base;
      int                    pos;
      logic [63:0]           num;
      logic [CHAR_WIDTH-1:0] digs[$];
      text.delete();
      kind = $urandom_range(99);
      if (kind >= 88) begin
         repeat ($urandom_range(1, 4)) text.push_back(CHAR_WIDTH'($urandom_range(255)));
         return;
      end
      base = (radix_now >= RADIX_MIN && radix_now <= RADIX_MAX) ? int'(radix_now) : 10;
      repeat ($urandom_range(0, 2)) text.push_back(space_char());
      case ($urandom_range(3))
         0: text.push_back(CH_PLUS);
         1: text.push_back(CH_MINUS);
         default: ;
      endcase
      case ($urandom_range(3))
         0: num = 64'($urandom_range(0, 1000));
         // straddle the largest magnitude that still fits
         1: num = 64'(32'h7fff_ffff) + 64'($urandom_range(0, 6)) - 64'd3;
         2: num = 64'($urandom) >> $urandom_range(0, 31);
         default: num = {$urandom, $urandom} >> $urandom_range(24, 63);
      endcase
      if ($urandom_range(19) != 0) begin
         if ($urandom_range(7) == 0) begin
            repeat ($urandom_range(1, 2)) text.push_back(digit_char(0));
         end
         do begin
            digs.push_front(digit_char(int'(num % 64'(base))));
            num = num / 64'(base);
         end while (num != 0);
         foreach (digs[i]) text.push_back(digs[i]);
      end
      if (text.size() == 0) begin
         text.push_back(CH_SPACE);
      end
      if (kind >= 72) begin
         pos = $urandom_range(text.size() - 1);
         case ($urandom_range(3))
            0: text[pos] = CHAR_WIDTH'($urandom_range(255));
            1: text.push_back(space_char());
            2: text[pos] = $urandom_range(1) ? CH_PLUS : CH_MINUS;
            default: begin
               if (base < 36) begin
                  text[pos] = digit_char($urandom_range(base, 35));
               end else begin
                  text[pos] = CHAR_WIDTH'($urandom_range(128, 255));
               end
            end
         endcase
      end
   endtask

   initial begin : stimulus
      int phase_no;
      int random_start;
      int done;
      int stop_at;

      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: reset radix readback, then the special cases at base 10
      csr_cycle(1'b0, '0);
      push_char(CH_TAB, 1'b0);
      push_char(CH_CR, 1'b0);
      push_string("-9");
      push_string(" ");
      push_string("+");
      push_string("1 ");
      push_string("-+");
      push_char(8'h00, 1'b1);
      push_char(8'hFF, 1'b1);
      push_string("a");
      // base 36: just past the limit, then exactly at it
      settle();
      set_radix(RADIX_MAX);
      push_string("Zzzzzz");
      push_string("zik0zj");
      // bases out of range on both sides
      settle();
      set_radix(RADIX_WIDTH'(0));
      push_string("5");
      settle();
      set_radix(RADIX_MAX + RADIX_WIDTH'(1));
      push_string("1");

      random_start = sent_chars;
      hold_at      = random_start + RANDOM_CHARS * 3 / 4;
      phase_no     = 0;
      while (sent_chars - random_start < RANDOM_CHARS) begin
         settle();
         if (phase_no <= 8) begin
            set_radix(radix_plan[phase_no]);
         end else if ($urandom_range(9) == 0) begin
            set_radix(RADIX_WIDTH'($urandom_range(63)));
         end else begin
            set_radix(RADIX_WIDTH'($urandom_range(2, 36)));
         end
         // receiver idles heavily first, then the sender does, then neither
         done = sent_chars - random_start;
         if (done < RANDOM_CHARS / 3) begin
            send_idle_pct = 16;
            recv_idle_pct = 69;
         end else if (done < RANDOM_CHARS * 2 / 3) begin
            send_idle_pct = 69;
            recv_idle_pct = 16;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // a bad base only ever reports one status, so keep those phases short
         stop_at = sent_chars + ((radix_now >= RADIX_MIN && radix_now <= RADIX_MAX) ? 110 : 30);
         while (sent_chars < stop_at && sent_chars - random_start < RANDOM_CHARS) begin
            build_string();
            push_text();
         end
         phase_no++;
      end

      settle();
      if (mismatches == 0) begin
         $display("radix_string_to_int_parser_test: done, clean");
      end else begin
         $display("radix_string_to_int_parser_test: done, errors");
      end
      $finish;
   end

endmodule
